>>> rtl/pba_pkg.sv
package pba_pkg;

	localparam int unsigned ARENA_PARAS = 4096;
	localparam int unsigned ADDR_W = $clog2(ARENA_PARAS);
	localparam int unsigned IDX_W = 18;

	localparam logic [1:0] KIND_NONE   = 2'd0;
	localparam logic [1:0] KIND_NORMAL = 2'd1;
	localparam logic [1:0] KIND_LAST   = 2'd2;
	localparam logic [1:0] KIND_JOINED = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOMEM   = 2'd1;
	localparam logic [1:0] ST_DESTROY = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;

	localparam logic [2:0] ACT_ALLOC     = 3'd0;
	localparam logic [2:0] ACT_LARGEST   = 3'd1;
	localparam logic [2:0] ACT_FREE      = 3'd2;
	localparam logic [2:0] ACT_RESIZE    = 3'd3;
	localparam logic [2:0] ACT_FREE_OWNR = 3'd4;

	localparam logic [1:0] FIT_FIRST   = 2'd0;
	localparam logic [1:0] FIT_BEST    = 2'd1;
	localparam logic [1:0] FIT_LAST    = 2'd2;
	localparam logic [1:0] FIT_LARGEST = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] owner;
		logic [15:0] size;
	} hdr_t;

	function automatic logic hdr_ok(hdr_t h);
		return (h.kind == KIND_NORMAL) || (h.kind == KIND_LAST);
	endfunction

endpackage

>>> rtl/pba_req_if.sv
interface pba_req_if;
	import pba_pkg::*;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [15:0] req_size;
	logic [1:0]  fit_mode;
	logic [15:0] block_seg;
	logic [15:0] owner;
	modport source (output valid, action, req_size, fit_mode, block_seg, owner, input ready);
	modport sink (input valid, action, req_size, fit_mode, block_seg, owner, output ready);
endinterface

>>> rtl/pba_rsp_if.sv
interface pba_rsp_if;
	import pba_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] seg_out;
	logic [15:0] size_out;
	modport source (output valid, status, seg_out, size_out, input ready);
	modport sink (input valid, status, seg_out, size_out, output ready);
endinterface

>>> rtl/pba_cfg_if.sv
interface pba_cfg_if;
	import pba_pkg::*;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/paragraph_block_allocator_core.sv
// Paragraph block allocator: keeps an arena of paragraphs as a chain of block
// headers in one 4096 x 34 synchronous RAM (one read, one write per cycle).
// req channel: one request per transfer (allocate, largest free, free, resize,
// free all of an owner). rsp channel: exactly one result per request, in order.
// cfg channel: writes base_segment; always ready, write only while idle.
// Processing: the chain walk reads each header from the RAM and then uses the
// registered data; a free header is joined with the free blocks after it,
// written back and evaluated. Finishing writes the chosen header and, if it
// is split, the rest. Free reads and clears one header (segment zero is
// answered as invalid without a RAM read); resize reads its header, joins
// if it must grow, and splits if it shrinks. One request is in work at a time.
// The result sits in an output register; the next request is taken while it
// waits. When rsp stalls, a finished request holds until the register frees.
// After reset the block clears every RAM entry (entry 0 becomes the single
// free last block) and accepts no request until the clear is done;
// base_segment resets to 0.
module paragraph_block_allocator_core (
	input  logic clk,
	input  logic arst_n,
	pba_req_if.sink   req,
	pba_rsp_if.source rsp,
	pba_cfg_if.sink   cfg
);
	import pba_pkg::*;

	typedef enum logic [18:0] {
		S_CLEAR = 19'd1 << 0,
		S_IDLE  = 19'd1 << 1,
		S_WRD   = 19'd1 << 2,
		S_WDAT  = 19'd1 << 3,
		S_JOIN  = 19'd1 << 4,
		S_JRD   = 19'd1 << 5,
		S_JDAT  = 19'd1 << 6,
		S_JWB   = 19'd1 << 7,
		S_WEVAL = 19'd1 << 8,
		S_AEND  = 19'd1 << 9,
		S_AFIN  = 19'd1 << 10,
		S_AFIN2 = 19'd1 << 11,
		S_FRD   = 19'd1 << 12,
		S_FDAT  = 19'd1 << 13,
		S_RRD   = 19'd1 << 14,
		S_RDAT  = 19'd1 << 15,
		S_RGROW = 19'd1 << 16,
		S_RSPL  = 19'd1 << 17,
		S_RESP  = 19'd1 << 18
	} state_t;

	state_t state_q;

	hdr_t mem [ARENA_PARAS];
	hdr_t rd_q;
	logic oob_q;
	hdr_t rd_hdr;

	logic              we;
	logic [ADDR_W-1:0] wa;
	hdr_t              wd;

	logic [ADDR_W-1:0] clr_q;
	logic [15:0]       base_q;

	logic [2:0]  act_q;
	logic [15:0] size_req_q;
	logic [1:0]  mode_q;
	logic [15:0] own_q;

	logic [IDX_W-1:0]  addr_q;
	logic [ADDR_W-1:0] p_q;
	hdr_t              cur_q;

	logic              have_big_q;
	logic [ADDR_W-1:0] big_idx_q;
	logic [15:0]       big_size_q;
	logic [1:0]        big_kind_q;
	logic              have_fnd_q;
	logic [ADDR_W-1:0] fnd_idx_q;
	logic [15:0]       fnd_size_q;
	logic [1:0]        fnd_kind_q;

	logic [1:0]  res_st_q;
	logic [15:0] res_seg_q;
	logic [15:0] res_size_q;

	logic        out_valid_q;
	logic [1:0]  out_st_q;
	logic [15:0] out_seg_q;
	logic [15:0] out_size_q;

	logic [IDX_W-1:0] next_cur;
	logic [IDX_W-1:0] next_rd;
	logic [IDX_W-1:0] split_idx;
	logic [15:0]      seg_p;
	logic             a_split;
	logic             addr_in;
	logic             aend_take_big;
	logic             aend_ok;
	logic             out_load;

	assign rd_hdr    = oob_q ? hdr_t'('0) : rd_q;
	assign next_cur  = {{(IDX_W-ADDR_W){1'b0}}, p_q} + {2'b0, cur_q.size} + IDX_W'(1);
	assign next_rd   = addr_q + {2'b0, rd_hdr.size} + IDX_W'(1);
	assign seg_p     = base_q + {{(16-ADDR_W){1'b0}}, addr_q[ADDR_W-1:0]};
	assign a_split   = (mode_q != FIT_LARGEST) && (size_req_q != fnd_size_q);
	assign addr_in   = (addr_q[IDX_W-1:ADDR_W] == '0);
	assign aend_take_big = (mode_q == FIT_LARGEST) && have_big_q && (big_size_q >= size_req_q);
	assign aend_ok   = aend_take_big ? (big_size_q != 16'd0)
	                                 : (have_fnd_q && (fnd_size_q != 16'd0));
	assign split_idx = (mode_q == FIT_LAST)
		? {{(IDX_W-ADDR_W){1'b0}}, fnd_idx_q}
			+ {2'b0, 16'(fnd_size_q - size_req_q - 16'd1)} + IDX_W'(1)
		: {{(IDX_W-ADDR_W){1'b0}}, fnd_idx_q} + {2'b0, size_req_q} + IDX_W'(1);
	assign out_load  = (state_q == S_RESP) && (!out_valid_q || rsp.ready);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_st_q;
	assign rsp.seg_out  = out_seg_q;
	assign rsp.size_out = out_size_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q  <= mem[addr_q[ADDR_W-1:0]];
		oob_q <= !addr_in;
	end

	always_comb begin
		we = 1'b0;
		wa = p_q;
		wd = '0;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wa = clr_q;
				if (clr_q == '0) begin
					wd = '{kind: KIND_LAST, owner: 16'd0, size: 16'(ARENA_PARAS - 1)};
				end
			end
			S_WDAT: begin
				if (act_q == ACT_FREE_OWNR && hdr_ok(rd_hdr) && rd_hdr.owner == own_q
						&& seg_p != 16'd0) begin
					we = 1'b1;
					wa = addr_q[ADDR_W-1:0];
					wd = '{kind: rd_hdr.kind, owner: 16'd0, size: rd_hdr.size};
				end
			end
			S_JDAT: begin
				if (rd_hdr.owner == 16'd0 && hdr_ok(rd_hdr)) begin
					we = 1'b1;
					wa = addr_q[ADDR_W-1:0];
					wd = '{kind: KIND_JOINED, owner: rd_hdr.owner, size: rd_hdr.size};
				end
			end
			S_JWB: begin
				we = 1'b1;
				wd = cur_q;
			end
			S_AFIN: begin
				we = 1'b1;
				wa = fnd_idx_q;
				if (a_split) begin
					if (mode_q == FIT_LAST) begin
						wd = '{kind: KIND_NORMAL, owner: 16'd0,
							size: 16'(fnd_size_q - size_req_q - 16'd1)};
					end else begin
						wd = '{kind: KIND_NORMAL, owner: own_q, size: size_req_q};
					end
				end else begin
					wd = '{kind: fnd_kind_q, owner: own_q, size: fnd_size_q};
				end
			end
			S_AFIN2: begin
				we = addr_in;
				wa = addr_q[ADDR_W-1:0];
				if (mode_q == FIT_LAST) begin
					wd = '{kind: fnd_kind_q, owner: own_q, size: size_req_q};
				end else begin
					wd = '{kind: fnd_kind_q, owner: 16'd0,
						size: 16'(fnd_size_q - size_req_q - 16'd1)};
				end
			end
			S_FDAT: begin
				if (hdr_ok(rd_hdr)) begin
					we = 1'b1;
					wa = addr_q[ADDR_W-1:0];
					wd = '{kind: rd_hdr.kind, owner: 16'd0, size: rd_hdr.size};
				end
			end
			S_RGROW: begin
				if (size_req_q < cur_q.size) begin
					we = 1'b1;
					wd = '{kind: KIND_NORMAL, owner: cur_q.owner, size: size_req_q};
				end
			end
			S_RSPL: begin
				we = addr_in;
				wa = addr_q[ADDR_W-1:0];
				wd = '{kind: cur_q.kind, owner: 16'd0,
					size: 16'(cur_q.size - size_req_q - 16'd1)};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				base_q <= cfg.data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(ARENA_PARAS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						act_q      <= req.action;
						size_req_q <= req.req_size;
						mode_q     <= req.fit_mode;
						own_q      <= req.owner;
						have_big_q <= 1'b0;
						big_size_q <= '0;
						have_fnd_q <= 1'b0;
						res_seg_q  <= '0;
						res_size_q <= '0;
						case (req.action)
							ACT_ALLOC, ACT_LARGEST, ACT_FREE_OWNR: begin
								addr_q  <= '0;
								state_q <= S_WRD;
							end
							ACT_FREE: begin
								addr_q <= {2'b0, 16'(req.block_seg - base_q)};
								if (req.block_seg == 16'd0) begin
									res_st_q <= ST_INVALID;
									state_q  <= S_RESP;
								end else begin
									state_q <= S_FRD;
								end
							end
							ACT_RESIZE: begin
								addr_q  <= {2'b0, 16'(req.block_seg - 16'd1 - base_q)};
								state_q <= S_RRD;
							end
							default: begin
								res_st_q <= ST_INVALID;
								state_q  <= S_RESP;
							end
						endcase
					end
				end
				S_WRD: begin
					state_q <= S_WDAT;
				end
				S_WDAT: begin
					cur_q <= rd_hdr;
					p_q   <= addr_q[ADDR_W-1:0];
					if (!hdr_ok(rd_hdr)) begin
						res_st_q <= ST_DESTROY;
						state_q  <= S_RESP;
					end else if (act_q == ACT_FREE_OWNR) begin
						if (rd_hdr.kind == KIND_LAST) begin
							res_st_q <= ST_OK;
							state_q  <= S_RESP;
						end else begin
							addr_q  <= next_rd;
							state_q <= S_WRD;
						end
					end else if (rd_hdr.owner == 16'd0) begin
						state_q <= S_JOIN;
					end else if (rd_hdr.kind == KIND_LAST) begin
						state_q <= S_AEND;
					end else begin
						addr_q  <= next_rd;
						state_q <= S_WRD;
					end
				end
				S_JOIN: begin
					if (cur_q.kind == KIND_NORMAL) begin
						addr_q  <= next_cur;
						state_q <= S_JRD;
					end else begin
						state_q <= S_JWB;
					end
				end
				S_JRD: begin
					state_q <= S_JDAT;
				end
				S_JDAT: begin
					if (rd_hdr.owner != 16'd0) begin
						state_q <= S_JWB;
					end else if (!hdr_ok(rd_hdr)) begin
						res_st_q   <= ST_DESTROY;
						res_size_q <= '0;
						state_q    <= S_RESP;
					end else begin
						cur_q.kind <= rd_hdr.kind;
						cur_q.size <= cur_q.size + rd_hdr.size + 16'd1;
						state_q    <= S_JOIN;
					end
				end
				S_JWB: begin
					state_q <= (act_q == ACT_RESIZE) ? S_RGROW : S_WEVAL;
				end
				S_WEVAL: begin
					if (!have_big_q || big_size_q < cur_q.size) begin
						have_big_q <= 1'b1;
						big_idx_q  <= p_q;
						big_size_q <= cur_q.size;
						big_kind_q <= cur_q.kind;
					end
					if (act_q == ACT_ALLOC && cur_q.size >= size_req_q
							&& mode_q == FIT_FIRST) begin
						fnd_idx_q  <= p_q;
						fnd_size_q <= cur_q.size;
						fnd_kind_q <= cur_q.kind;
						state_q    <= S_AFIN;
					end else begin
						if (act_q == ACT_ALLOC && cur_q.size >= size_req_q
								&& (mode_q == FIT_LAST || (mode_q == FIT_BEST
								&& (!have_fnd_q || fnd_size_q > cur_q.size)))) begin
							have_fnd_q <= 1'b1;
							fnd_idx_q  <= p_q;
							fnd_size_q <= cur_q.size;
							fnd_kind_q <= cur_q.kind;
						end
						if (cur_q.kind == KIND_LAST) begin
							state_q <= S_AEND;
						end else begin
							addr_q  <= next_cur;
							state_q <= S_WRD;
						end
					end
				end
				S_AEND: begin
					if (act_q == ACT_LARGEST) begin
						res_st_q   <= (big_size_q != 16'd0) ? ST_OK : ST_NOMEM;
						res_size_q <= big_size_q;
						state_q    <= S_RESP;
					end else if (!aend_ok) begin
						res_st_q   <= ST_NOMEM;
						res_size_q <= big_size_q;
						state_q    <= S_RESP;
					end else begin
						if (aend_take_big) begin
							fnd_idx_q  <= big_idx_q;
							fnd_size_q <= big_size_q;
							fnd_kind_q <= big_kind_q;
						end
						state_q <= S_AFIN;
					end
				end
				S_AFIN: begin
					res_st_q  <= ST_OK;
					res_seg_q <= base_q + {{(16-ADDR_W){1'b0}}, fnd_idx_q};
					if (a_split) begin
						addr_q  <= split_idx;
						state_q <= S_AFIN2;
					end else begin
						res_size_q <= (mode_q == FIT_LARGEST) ? fnd_size_q : 16'd0;
						state_q    <= S_RESP;
					end
				end
				S_AFIN2: begin
					if (mode_q == FIT_LAST) begin
						res_seg_q <= base_q + addr_q[15:0];
					end
					state_q <= S_RESP;
				end
				S_FRD: begin
					state_q <= S_FDAT;
				end
				S_FDAT: begin
					res_st_q <= hdr_ok(rd_hdr) ? ST_OK : ST_INVALID;
					state_q  <= S_RESP;
				end
				S_RRD: begin
					state_q <= S_RDAT;
				end
				S_RDAT: begin
					cur_q <= rd_hdr;
					p_q   <= addr_q[ADDR_W-1:0];
					if (!hdr_ok(rd_hdr)) begin
						res_st_q <= ST_DESTROY;
						state_q  <= S_RESP;
					end else if (size_req_q > rd_hdr.size) begin
						state_q <= S_JOIN;
					end else begin
						state_q <= S_RGROW;
					end
				end
				S_RGROW: begin
					if (size_req_q > cur_q.size) begin
						res_st_q   <= ST_NOMEM;
						res_size_q <= cur_q.size;
						state_q    <= S_RESP;
					end else if (size_req_q < cur_q.size) begin
						addr_q  <= next_cur - {2'b0, cur_q.size} + {2'b0, size_req_q};
						state_q <= S_RSPL;
					end else begin
						res_st_q <= ST_OK;
						state_q  <= S_RESP;
					end
				end
				S_RSPL: begin
					res_st_q <= ST_OK;
					state_q  <= S_RESP;
				end
				S_RESP: begin
					if (out_load) begin
						out_st_q    <= res_st_q;
						out_seg_q   <= res_seg_q;
						out_size_q  <= res_size_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> tb/tb_top.sv
module tb_top;
	import pba_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 200000;

	typedef struct {
		logic [2:0]  action;
		logic [15:0] req_size;
		logic [1:0]  fit_mode;
		logic [15:0] block_seg;
		logic [15:0] owner;
	} request_t;

	typedef struct {
		logic [1:0]  status;
		logic [15:0] seg;
		logic [15:0] size;
	} answer_t;

	logic clk;
	logic arst_n;

	pba_req_if req_if();
	pba_rsp_if rsp_if();
	pba_cfg_if cfg_if();

	paragraph_block_allocator_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source),
		.cfg(cfg_if.sink)
	);

	// arena shadow
	logic [1:0]  sh_kind[ARENA_PARAS];
	logic [15:0] sh_owner[ARENA_PARAS];
	logic [15:0] sh_size[ARENA_PARAS];
	logic [15:0] sh_base;

	answer_t     pending_answers[$];
	int unsigned owned_idx[$];
	int unsigned n_errors;
	int unsigned n_mismatch;
	bit          no_idle;
	bit          hold_request;
	int unsigned alloc_idx;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [1:0] kind_at(int unsigned i);
		return (i < ARENA_PARAS) ? sh_kind[i] : KIND_NONE;
	endfunction

	function automatic logic [15:0] owner_at(int unsigned i);
		return (i < ARENA_PARAS) ? sh_owner[i] : 16'd0;
	endfunction

	function automatic bit hdr_valid(int unsigned i);
		logic [1:0] k;
		k = kind_at(i);
		return (k == KIND_NORMAL) || (k == KIND_LAST);
	endfunction

	function automatic int unsigned next_hdr(int unsigned i);
		return i + sh_size[i] + 1;
	endfunction

	function automatic bit merge_free(int unsigned i);
		int unsigned q;
		while (sh_kind[i] == KIND_NORMAL) begin
			q = next_hdr(i);
			if (owner_at(q) != 16'd0)
				break;
			if (!hdr_valid(q))
				return 1'b0;
			sh_kind[i] = sh_kind[q];
			sh_size[i] = sh_size[i] + sh_size[q] + 16'd1;
			sh_kind[q] = KIND_JOINED;
		end
		return 1'b1;
	endfunction

	function automatic void write_hdr(int unsigned i, logic [1:0] k, logic [15:0] o,
			logic [15:0] s);
		if (i < ARENA_PARAS) begin
			sh_kind[i] = k;
			sh_owner[i] = o;
			sh_size[i] = s;
		end
	endfunction

	function automatic answer_t model_alloc(int unsigned req, logic [1:0] mode,
			logic [15:0] own);
		answer_t a;
		int unsigned p, big, found, fsize, rest;
		bit have_big, have_found, first_hit;
		logic [1:0] rk;
		a = '{ST_OK, 16'd0, 16'd0};
		p = 0; big = 0; found = 0;
		have_big = 0; have_found = 0; first_hit = 0;
		forever begin
			if (!hdr_valid(p)) begin
				a.status = ST_DESTROY;
				return a;
			end
			if (sh_owner[p] == 16'd0) begin
				if (!merge_free(p)) begin
					a.status = ST_DESTROY;
					return a;
				end
				if (!have_big || sh_size[big] < sh_size[p]) begin
					big = p;
					have_big = 1;
				end
				if (sh_size[p] >= req) begin
					if (mode == FIT_FIRST) begin
						found = p;
						have_found = 1;
						first_hit = 1;
						break;
					end
					if (mode == FIT_BEST) begin
						if (!have_found || sh_size[found] > sh_size[p]) begin
							found = p;
							have_found = 1;
						end
					end else if (mode == FIT_LAST) begin
						found = p;
						have_found = 1;
					end
				end
			end
			if (sh_kind[p] == KIND_LAST)
				break;
			p = next_hdr(p);
		end
		if (!first_hit) begin
			if (mode == FIT_LARGEST && have_big && sh_size[big] >= req) begin
				found = big;
				have_found = 1;
			end
			if (!have_found || sh_size[found] == 16'd0) begin
				a.status = ST_NOMEM;
				a.size = have_big ? sh_size[big] : 16'd0;
				return a;
			end
		end
		if (mode != FIT_LARGEST && req != sh_size[found]) begin
			fsize = sh_size[found];
			if (mode == FIT_LAST) begin
				rest = found;
				rk = sh_kind[rest];
				sh_size[rest] = 16'(fsize - req - 1);
				sh_kind[rest] = KIND_NORMAL;
				found = next_hdr(rest);
				write_hdr(found, rk, 16'd0, 16'(req));
			end else begin
				rest = found + req + 1;
				write_hdr(rest, sh_kind[found], 16'd0, 16'(fsize - req - 1));
				sh_kind[found] = KIND_NORMAL;
				sh_size[found] = 16'(req);
			end
		end
		if (found < ARENA_PARAS)
			sh_owner[found] = own;
		alloc_idx = found;
		a.seg = 16'(sh_base + found);
		a.size = (mode == FIT_LARGEST && found < ARENA_PARAS) ? sh_size[found] : 16'd0;
		return a;
	endfunction

	function automatic answer_t model_largest();
		answer_t a;
		int unsigned p;
		logic [15:0] best;
		a = '{ST_OK, 16'd0, 16'd0};
		p = 0;
		best = 0;
		forever begin
			if (!hdr_valid(p)) begin
				a.status = ST_DESTROY;
				return a;
			end
			if (sh_owner[p] == 16'd0) begin
				if (!merge_free(p)) begin
					a.status = ST_DESTROY;
					return a;
				end
				if (best < sh_size[p])
					best = sh_size[p];
			end
			if (sh_kind[p] == KIND_LAST)
				break;
			p = next_hdr(p);
		end
		a.size = best;
		a.status = (best != 0) ? ST_OK : ST_NOMEM;
		return a;
	endfunction

	function automatic logic [1:0] model_free(logic [15:0] seg);
		int unsigned i;
		if (seg == 16'd0)
			return ST_INVALID;
		i = 16'(seg - sh_base);
		if (!hdr_valid(i))
			return ST_INVALID;
		sh_owner[i] = 16'd0;
		return ST_OK;
	endfunction

	function automatic answer_t model_resize(logic [15:0] seg, int unsigned req);
		answer_t a;
		int unsigned i;
		a = '{ST_OK, 16'd0, 16'd0};
		i = 16'(seg - 16'd1 - sh_base);
		if (!hdr_valid(i)) begin
			a.status = ST_DESTROY;
			return a;
		end
		if (req > sh_size[i]) begin
			if (!merge_free(i)) begin
				a.status = ST_DESTROY;
				return a;
			end
			if (req > sh_size[i]) begin
				a.status = ST_NOMEM;
				a.size = sh_size[i];
				return a;
			end
		end
		if (req < sh_size[i]) begin
			write_hdr(i + req + 1, sh_kind[i], 16'd0, 16'(sh_size[i] - req - 1));
			sh_size[i] = 16'(req);
			sh_kind[i] = KIND_NORMAL;
		end
		return a;
	endfunction

	function automatic logic [1:0] model_free_owner(logic [15:0] own);
		int unsigned p;
		p = 0;
		while (hdr_valid(p)) begin
			if (sh_owner[p] == own)
				void'(model_free(16'(sh_base + p)));
			if (sh_kind[p] == KIND_LAST)
				return ST_OK;
			p = next_hdr(p);
		end
		return ST_DESTROY;
	endfunction

	function automatic answer_t predict_answer(request_t r);
		answer_t a;
		a = '{ST_OK, 16'd0, 16'd0};
		alloc_idx = ARENA_PARAS;
		case (r.action)
			ACT_ALLOC: a = model_alloc(r.req_size, r.fit_mode, r.owner);
			ACT_LARGEST: a = model_largest();
			ACT_FREE: a.status = model_free(r.block_seg);
			ACT_RESIZE: a = model_resize(r.block_seg, r.req_size);
			ACT_FREE_OWNR: a.status = model_free_owner(r.owner);
			default: a.status = ST_INVALID;
		endcase
		if (a.status == ST_DESTROY || a.status == ST_INVALID) begin
			a.seg = 16'd0;
			a.size = 16'd0;
		end
		return a;
	endfunction

	function automatic void shadow_reset();
		for (int i = 0; i < ARENA_PARAS; i++) begin
			sh_kind[i] = KIND_NONE;
			sh_owner[i] = 16'd0;
			sh_size[i] = 16'd0;
		end
		sh_kind[0] = KIND_LAST;
		sh_size[0] = 16'(ARENA_PARAS - 1);
		sh_base = 16'd0;
	endfunction

	task automatic send_request(request_t r);
		answer_t a;
		@(negedge clk);
		req_if.valid = 1'b1;
		req_if.action = r.action;
		req_if.req_size = r.req_size;
		req_if.fit_mode = r.fit_mode;
		req_if.block_seg = r.block_seg;
		req_if.owner = r.owner;
		do @(posedge clk); while (!req_if.ready);
		a = predict_answer(r);
		pending_answers.push_back(a);
		if (a.status == ST_OK && alloc_idx < ARENA_PARAS) begin
			owned_idx.push_back(alloc_idx);
			if (owned_idx.size() > 64)
				void'(owned_idx.pop_front());
		end
	endtask

	task automatic sender_gap();
		int unsigned r, n;
		r = $urandom % 16;
		n = no_idle ? 0 : (r < 10) ? 0 : (r < 15) ? $urandom_range(1, 3)
			: $urandom_range(10, 40);
		if (n > 0) begin
			@(negedge clk);
			req_if.valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic go_idle();
		@(negedge clk);
		req_if.valid = 1'b0;
		wait (pending_answers.size() == 0);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_base(logic [15:0] value);
		go_idle();
		cfg_if.valid = 1'b1;
		cfg_if.data = value;
		do @(posedge clk); while (!cfg_if.ready);
		sh_base = value;
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	function automatic logic [15:0] pick_header_seg();
		if (owned_idx.size() != 0 && $urandom % 8 != 0)
			return 16'(sh_base + owned_idx[$urandom % owned_idx.size()]);
		return 16'($urandom_range(0, 65535));
	endfunction

	function automatic request_t random_request();
		request_t r;
		int unsigned k;
		k = $urandom % 100;
		r.action = ACT_ALLOC;
		r.req_size = ($urandom % 10 == 0) ? 16'($urandom_range(0, 65535))
			: 16'($urandom_range(0, 200));
		r.fit_mode = 2'($urandom % 4);
		r.block_seg = 16'($urandom_range(0, 65535));
		r.owner = ($urandom % 8 == 0) ? 16'($urandom_range(1, 65535))
			: 16'($urandom_range(1, 6));
		if (k < 35) begin
			r.action = ACT_ALLOC;
		end else if (k < 45) begin
			r.action = ACT_LARGEST;
		end else if (k < 65) begin
			r.action = ACT_FREE;
			r.block_seg = pick_header_seg();
		end else if (k < 80) begin
			r.action = ACT_RESIZE;
			r.block_seg = pick_header_seg() + 16'd1;
			r.req_size = ($urandom % 10 == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(0, 300));
		end else if (k < 88) begin
			r.action = ACT_FREE_OWNR;
			r.owner = 16'($urandom_range(1, 6));
		end else if (k < 92) begin
			r.action = 3'($urandom_range(5, 7));
		end else begin
			r.action = ACT_ALLOC;
			r.fit_mode = FIT_LARGEST;
		end
		return r;
	endfunction

	task automatic run_random(int unsigned n);
		repeat (n) begin
			send_request(random_request());
			sender_gap();
		end
	endtask

	task automatic test_directed();
		request_t list[$];
		list.push_back('{ACT_LARGEST, 16'd0, FIT_FIRST, 16'd0, 16'd1});
		list.push_back('{ACT_ALLOC, 16'd65535, FIT_FIRST, 16'd0, 16'd1});
		list.push_back('{ACT_ALLOC, 16'd0, FIT_FIRST, 16'd0, 16'd1});
		list.push_back('{ACT_ALLOC, 16'd10, FIT_BEST, 16'd0, 16'd2});
		list.push_back('{ACT_ALLOC, 16'd20, FIT_LAST, 16'd0, 16'd65535});
		list.push_back('{ACT_ALLOC, 16'd0, FIT_BEST, 16'd0, 16'd3});
		list.push_back('{ACT_ALLOC, 16'd5, FIT_FIRST, 16'd0, 16'd0});
		list.push_back('{ACT_FREE, 16'd0, FIT_FIRST, 16'd0, 16'd1});
		list.push_back('{ACT_FREE, 16'd0, FIT_FIRST, 16'd65535, 16'd1});
		list.push_back('{ACT_FREE, 16'd0, FIT_FIRST, 16'd1, 16'd1});
		list.push_back('{ACT_ALLOC, 16'd4000, FIT_FIRST, 16'd0, 16'd4});
		list.push_back('{ACT_RESIZE, 16'd2, FIT_FIRST, 16'd2, 16'd1});
		list.push_back('{ACT_RESIZE, 16'd60, FIT_FIRST, 16'd2, 16'd1});
		list.push_back('{ACT_RESIZE, 16'd65535, FIT_FIRST, 16'd2, 16'd1});
		list.push_back('{ACT_RESIZE, 16'd3, FIT_FIRST, 16'd65535, 16'd1});
		list.push_back('{ACT_FREE_OWNR, 16'd0, FIT_FIRST, 16'd0, 16'd65535});
		list.push_back('{ACT_ALLOC, 16'd65535, FIT_LARGEST, 16'd0, 16'd5});
		list.push_back('{ACT_LARGEST, 16'd0, FIT_FIRST, 16'd0, 16'd1});
		list.push_back('{ACT_ALLOC, 16'd0, FIT_LARGEST, 16'd0, 16'd5});
		list.push_back('{3'd5, 16'd65535, FIT_LARGEST, 16'd65535, 16'd65535});
		list.push_back('{3'd6, 16'd0, FIT_FIRST, 16'd0, 16'd1});
		list.push_back('{3'd7, 16'd0, FIT_FIRST, 16'd0, 16'd1});
		list.push_back('{ACT_FREE_OWNR, 16'd0, FIT_FIRST, 16'd0, 16'd5});
		list.push_back('{ACT_LARGEST, 16'd0, FIT_FIRST, 16'd0, 16'd1});
		foreach (list[i]) begin
			send_request(list[i]);
			sender_gap();
		end
	endtask

	task automatic test_base_segments();
		write_base(16'hFFFF);
		run_random(80);
		write_base(16'hF800);
		run_random(80);
		write_base(16'($urandom_range(1, 65534)));
		no_idle = 1'b1;
		run_random(60);
		no_idle = 1'b0;
		write_base(16'd0);
		run_random(120);
	endtask

	task automatic test_backpressure();
		hold_request = 1'b1;
		no_idle = 1'b1;
		repeat (30) send_request(random_request());
		no_idle = 1'b0;
		run_random(40);
	endtask

	// response ready: random stalls, plus one long hold-off on request
	initial begin
		int unsigned stall_left, r;
		rsp_if.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_if.ready = 1'b0;
				repeat (300) @(negedge clk);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready = 1'b0;
			end else if (no_idle) begin
				rsp_if.ready = 1'b1;
			end else begin
				r = $urandom % 16;
				stall_left = (r < 3) ? $urandom_range(0, 3)
					: (r == 3) ? $urandom_range(10, 60) : 0;
				rsp_if.ready = (stall_left == 0);
			end
		end
	end

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_answers.size() == 0) begin
				n_errors++;
				$display("unexpected result: status %0d seg %h size %h",
					rsp_if.status, rsp_if.seg_out, rsp_if.size_out);
			end else begin
				e = pending_answers.pop_front();
				if (rsp_if.status !== e.status || rsp_if.seg_out !== e.seg
						|| rsp_if.size_out !== e.size) begin
					n_errors++;
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("mismatch: exp %0d/%h/%h got %0d/%h/%h",
							e.status, e.seg, e.size,
							rsp_if.status, rsp_if.seg_out, rsp_if.size_out);
				end
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
					|| (cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("FAIL paragraph_block_allocator_core");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.action = ACT_LARGEST;
		req_if.req_size = 16'd0;
		req_if.fit_mode = FIT_FIRST;
		req_if.block_seg = 16'd0;
		req_if.owner = 16'd0;
		cfg_if.valid = 1'b0;
		cfg_if.data = 16'd0;
		n_errors = 0;
		n_mismatch = 0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		shadow_reset();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_base_segments();
		test_backpressure();
		@(negedge clk);
		req_if.valid = 1'b0;
		wait (pending_answers.size() == 0);
		repeat (50) @(posedge clk);
		if (n_errors == 0)
			$display("PASS paragraph_block_allocator_core");
		else
			$display("FAIL paragraph_block_allocator_core");
		$finish;
	end

endmodule
